// ===== src/aesbm_pkg.sv =====
// Shared types, constants and AES byte functions for the AES-128 block mode cipher.
// No dependencies.
package aesbm_pkg;

  localparam int BlkW = 128;
  localparam int NumRounds = 10;
  localparam int RndW = 4;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ECB = 2'd0;
  localparam mode_t MODE_CBC = 2'd1;
  localparam mode_t MODE_CFB = 2'd2;
  localparam mode_t MODE_OFB = 2'd3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_KEY_HIGH = 3'd0;
  localparam cfg_idx_t REG_KEY_LOW = 3'd1;
  localparam cfg_idx_t REG_IV_HIGH = 3'd2;
  localparam cfg_idx_t REG_IV_LOW = 3'd3;
  localparam cfg_idx_t REG_CHAIN_MODE = 3'd4;
  localparam cfg_idx_t REG_DECRYPT_SEL = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;       // start of item: form cipher input
    logic key_start;  // start of key expansion
    logic key_step;   // one key expansion round
    logic round;      // one cipher round
    logic finish;     // produce result and update chain
    logic [RndW-1:0] rnd;
  } dp_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sub_fwd_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sub_fwd_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sub_inv_calc(input logic [7:0] y);
    sub_inv_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t make_fwd();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = sub_fwd_calc(8'(i));
    make_fwd = t;
  endfunction

  function automatic sbox_t make_inv();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = sub_inv_calc(8'(i));
    make_inv = t;
  endfunction

  localparam sbox_t SboxFwd = make_fwd();
  localparam sbox_t SboxInv = make_inv();

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] get_byte(input logic [BlkW-1:0] s, input int i);
    get_byte = s[BlkW-1-8*i -: 8];
  endfunction

endpackage

// ===== src/aesbm_datapath.sv =====
// Datapath: key schedule registers, round state, chaining value and result register.
// Depends on aesbm_pkg.
module aesbm_datapath (
  input  logic                  clk,
  input  aesbm_pkg::dp_cmd_t    cmd,
  input  logic [aesbm_pkg::BlkW-1:0] key,
  input  logic [aesbm_pkg::BlkW-1:0] iv,
  input  aesbm_pkg::mode_t      mode,
  input  logic                  dec,
  input  logic                  rst,
  input  logic                  in_restart,
  input  logic [127:0]          in_data,
  input  logic [4:0]            in_count,
  output logic [127:0]          res_data,
  output logic                  res_err
);
  import aesbm_pkg::*;

  logic [127:0] rk [NumRounds+1];
  logic [127:0] kw;
  logic [7:0]   rc;
  logic [127:0] st, st_next;
  logic [127:0] chain, data;
  logic         use_dec;
  logic [4:0]   cnt;
  logic         err;

  // key expansion: one round key per step
  logic [127:0] kw_next;
  always_comb begin
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {SboxFwd[kw[23:16]] ^ rc, SboxFwd[kw[15:8]], SboxFwd[kw[7:0]], SboxFwd[kw[31:24]]};
    w0 = kw[127:96] ^ t;
    w1 = kw[95:64] ^ w0;
    w2 = kw[63:32] ^ w1;
    w3 = kw[31:0] ^ w2;
    kw_next = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      kw <= key;
      rc <= 8'h01;
      rk[0] <= key;
    end else if (cmd.key_step) begin
      kw <= kw_next;
      rc <= xtime(rc);
      rk[cmd.rnd] <= kw_next;
    end
  end

  // cipher round
  logic [127:0] rkey;
  assign rkey = rk[use_dec ? RndW'(NumRounds) - cmd.rnd : cmd.rnd];

  always_comb begin
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] m [16];
    logic last;
    last = (cmd.rnd == RndW'(NumRounds));
    for (int i = 0; i < 16; i++) s[i] = get_byte(st, i);
    if (!use_dec) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) o[r + 4*c] = SboxFwd[s[r + 4*((c + r) & 3)]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          m[4*c + r] = gmul(8'd2, o[4*c + r]) ^ gmul(8'd3, o[4*c + ((r + 1) & 3)])
                     ^ o[4*c + ((r + 2) & 3)] ^ o[4*c + ((r + 3) & 3)];
      for (int i = 0; i < 16; i++) begin
        st_next[127-8*i -: 8] = (last ? o[i] : m[i]) ^ get_byte(rkey, i);
      end
    end else begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) o[r + 4*((c + r) & 3)] = SboxInv[s[r + 4*c]];
      for (int i = 0; i < 16; i++) o[i] = o[i] ^ get_byte(rkey, i);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          m[4*c + r] = gmul(8'd14, o[4*c + r]) ^ gmul(8'd11, o[4*c + ((r + 1) & 3)])
                     ^ gmul(8'd13, o[4*c + ((r + 2) & 3)]) ^ gmul(8'd9, o[4*c + ((r + 3) & 3)]);
      for (int i = 0; i < 16; i++) st_next[127-8*i -: 8] = last ? o[i] : m[i];
    end
  end

  logic [127:0] ch_now;
  logic [4:0]   c16;
  assign ch_now = in_restart ? iv : chain;
  assign c16 = (in_count > 5'd16) ? 5'd16 : in_count;

  logic [127:0] o_full, o_mask;
  always_comb begin
    o_full = st;
    unique case (mode)
      MODE_ECB: o_full = st;
      MODE_CBC: o_full = dec ? (st ^ chain) : st;
      MODE_CFB, MODE_OFB: o_full = data ^ st;
      default: o_full = st;
    endcase
    for (int i = 0; i < 16; i++)
      o_mask[127-8*i -: 8] = (5'(i) < cnt) ? o_full[127-8*i -: 8] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.load) begin
      chain <= ch_now;
      data <= in_data;
      cnt <= c16;
      err <= (mode == MODE_ECB || mode == MODE_CBC) && c16 != 5'd16;
      use_dec <= dec && (mode == MODE_ECB || mode == MODE_CBC);
      unique case (mode)
        MODE_ECB: st <= in_data ^ (dec ? rk[NumRounds] : rk[0]);
        MODE_CBC: st <= dec ? (in_data ^ rk[NumRounds]) : (in_data ^ ch_now ^ rk[0]);
        default: st <= ch_now ^ rk[0];
      endcase
    end else if (cmd.round) begin
      st <= st_next;
    end else if (cmd.finish) begin
      res_err <= err;
      res_data <= err ? '0 : o_mask;
      if (!err && cnt == 5'd16) begin
        unique case (mode)
          MODE_ECB: chain <= chain;
          MODE_CBC: chain <= dec ? data : st;
          MODE_CFB: chain <= dec ? data : o_full;
          MODE_OFB: chain <= st;
          default: chain <= chain;
        endcase
      end
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.key_start, cmd.key_step, cmd.round, cmd.finish}))
    else $error("overlapping datapath commands");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cnt <= 5'd16) else $error("block count out of range");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && err) |=> (res_data == '0 && res_err))
    else $error("length error with nonzero result");
endmodule

// ===== src/aesbm_ctrl.sv =====
// Controller: key expansion sequencing and per-block round sequencing with handshakes.
// Depends on aesbm_pkg.
module aesbm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_write,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output aesbm_pkg::dp_cmd_t cmd
);
  import aesbm_pkg::*;

  typedef enum logic [4:0] {
    S_KEY  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RUN  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [RndW-1:0] rnd, rnd_next;
  logic key_pend, key_pend_next;

  assign in_ready = (state == S_IDLE) && !key_pend;
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    key_pend_next = key_pend | key_write;
    cmd = '0;
    cmd.rnd = rnd;
    unique case (state)
      S_KEY: begin
        cmd.key_step = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == RndW'(NumRounds)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (key_pend) begin
          cmd.key_start = 1'b1;
          key_pend_next = key_write;
          rnd_next = RndW'(1);
          state_next = S_KEY;
        end else if (in_valid) begin
          cmd.load = 1'b1;
          rnd_next = RndW'(1);
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == RndW'(NumRounds)) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd <= '0;
      key_pend <= 1'b1;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      key_pend <= key_pend_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && rnd == RndW'(NumRounds)) |=> state == S_FIN)
    else $error("round count overrun");
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_pend |-> !in_ready) else $error("accept during key update");
endmodule

// ===== src/aes128_block_mode_cipher.sv =====
// Top level of the AES-128 ECB/CBC/CFB/OFB cipher: config registers, controller, datapath.
// Depends on aesbm_pkg, aesbm_ctrl, aesbm_datapath.
//  channel | handshake                  | payload
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  in      | in_valid / in_ready        | data_high, data_low, byte_count, restart
//  out     | out_valid / out_ready      | result_high, result_low, length_error
// Without stalls a block runs through load, ten rounds, finish and result between input
// transfer and result transfer; the next block is taken only after the result transfer.
// A stalled result holds the controller; input waits until the result transfer.
// A key write triggers a key expansion once the controller is idle; reset runs one before the first block.
module aes128_block_mode_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic [4:0]  byte_count,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic        length_error
);
  import aesbm_pkg::*;

  logic [63:0] key_high, key_low, iv_high, iv_low;
  mode_t chain_mode;
  logic decrypt_sel;
  logic cfg_fire, key_write;
  dp_cmd_t cmd;
  logic [127:0] res;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign key_write = cfg_fire && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      iv_high <= '0;
      iv_low <= '0;
      chain_mode <= MODE_ECB;
      decrypt_sel <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW: key_low <= cfg_data;
        REG_IV_HIGH: iv_high <= cfg_data;
        REG_IV_LOW: iv_low <= cfg_data;
        REG_CHAIN_MODE: chain_mode <= cfg_data[1:0];
        REG_DECRYPT_SEL: decrypt_sel <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aesbm_ctrl u_ctrl (
    .clk, .rst, .key_write, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  aesbm_datapath u_dp (
    .clk, .cmd, .rst,
    .key({key_high, key_low}),
    .iv({iv_high, iv_low}),
    .mode(chain_mode),
    .dec(decrypt_sel),
    .in_restart(restart),
    .in_data({data_high, data_low}),
    .in_count(byte_count),
    .res_data(res),
    .res_err(length_error)
  );

  assign result_high = res[127:64];
  assign result_low = res[63:0];
endmodule
